// ----- sv/gspf_pkg.sv -----
// ---------------------------------------------------------------------------
// gspf_pkg
// Shared types, constants and codes for the grid shortest-path finder.
// ---------------------------------------------------------------------------
package gspf_pkg;

	localparam int MAX_SIDE = 32;
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int CW = $clog2(MAX_SIDE);
	localparam int AW = $clog2(CELLS);
	localparam logic [13:0] UNREACHED = 14'd16383;
	localparam logic [13:0] DIST_MAX = 14'd16382;
	localparam logic [10:0] LEN_MAX = 11'd2047;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] KIND_OBSTACLE = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_NOPATH = 2'd2;

	localparam logic [1:0] VIS_NONE = 2'd0;
	localparam logic [1:0] VIS_WAIT = 2'd1;
	localparam logic [1:0] VIS_DONE = 2'd2;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_START_X = 2'd2;
	localparam logic [1:0] REG_START_Y = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [1:0] cell_kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [10:0] path_length;
		logic [13:0] finish_distance;
		logic [13:0] cell_distance;
		logic cell_on_path;
	} result_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLEAR, S_SEED, S_SCAN, S_SCAN_END, S_SETTLE, S_RELAX, S_TRACE,
		S_TRACE_END, S_READ, S_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic latch_cmd;
		logic do_write;
		logic clear_start;
		logic clear_step;
		logic seed;
		logic scan_start;
		logic scan_step;
		logic settle;
		logic relax_start;
		logic relax_step;
		logic trace_start;
		logic trace_step;
		logic finish_ok;
		logic finish_fail;
		logic finish_plain;
	} ctrl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic start_ok;
		logic any_found;
		logic is_finish;
		logic relax_last;
		logic trace_end;
	} stat_t;

endpackage

// ----- sv/gspf_ctrl.sv -----
// ---------------------------------------------------------------------------
// gspf_ctrl
// Sequencer for writes, reads, the search loop and the trace back.
// ---------------------------------------------------------------------------
module gspf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] op,
	input gspf_pkg::stat_t st,
	output gspf_pkg::ctrl_t ctl,
	output logic busy
);
	import gspf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_INIT: begin
				ctl.clear_step = 1'b1;
				if (st.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.latch_cmd = 1'b1;
					unique case (op)
						OP_WRITE: begin
							ctl.do_write = 1'b1;
							state_d = S_DONE;
						end
						OP_RUN: begin
							ctl.clear_start = 1'b1;
							state_d = S_CLEAR;
						end
						OP_READ: state_d = S_READ;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (st.clear_last) begin
					if (st.start_ok) begin
						state_d = S_SEED;
					end else begin
						ctl.finish_fail = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_SEED: begin
				ctl.seed = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (st.scan_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				if (!st.any_found) begin
					ctl.finish_fail = 1'b1;
					state_d = S_IDLE;
				end else begin
					ctl.settle = 1'b1;
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				if (st.is_finish) begin
					ctl.trace_start = 1'b1;
					state_d = S_TRACE;
				end else begin
					ctl.relax_start = 1'b1;
					state_d = S_RELAX;
				end
			end
			S_RELAX: begin
				ctl.relax_step = 1'b1;
				if (st.relax_last) begin
					ctl.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_TRACE: begin
				ctl.trace_step = 1'b1;
				if (st.trace_end) state_d = S_TRACE_END;
			end
			S_TRACE_END: begin
				ctl.finish_ok = 1'b1;
				state_d = S_IDLE;
			end
			S_READ: state_d = S_DONE;
			S_DONE: begin
				ctl.finish_plain = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- sv/gspf_dp.sv -----
// ---------------------------------------------------------------------------
// gspf_dp
// Cell stores, frontier scan, neighbor relaxation and trace back datapath.
// ---------------------------------------------------------------------------
module gspf_dp (
	input logic clk,
	input logic arst_n,
	input gspf_pkg::cmd_t cmd,
	input gspf_pkg::ctrl_t ctl,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [5:0] cfg_data,
	output gspf_pkg::stat_t st,
	output logic done,
	output gspf_pkg::result_t res
);
	import gspf_pkg::*;

	// Each store has one port, so each scan, relax and trace step reads a cell, waits for
	// registered data, then acts: sub-phase bit ph_q splits each visit.
	logic [1:0] kind_mem [CELLS];
	logic [13:0] dist_mem [CELLS];
	logic [1:0] vis_mem [CELLS];
	logic path_mem [CELLS];

	logic [5:0] width_q, height_q;
	logic [4:0] sx_q, sy_q;
	cmd_t cmd_q;
	logic [10:0] flen_q;
	logic [13:0] fdist_q;
	result_t res_q;
	logic done_q;

	logic [AW:0] cnt_q;
	logic ph_q;
	logic [AW-1:0] addr;
	logic [1:0] kind_rd;
	logic [13:0] dist_rd;
	logic [1:0] vis_rd;
	logic path_rd;

	logic any_q;
	logic [13:0] bd_q;
	logic [CW-1:0] bx_q, by_q;
	logic [3:0] nb_q;
	logic [CW-1:0] tx_q, ty_q;
	logic [10:0] steps_q;
	logic tdone_q;

	logic [CW:0] w_eff, h_eff;
	always_comb begin
		if (width_q == 6'd0) w_eff = (CW+1)'(1);
		else if (width_q > 6'(MAX_SIDE)) w_eff = (CW+1)'(MAX_SIDE);
		else w_eff = (CW+1)'(width_q);
		if (height_q == 6'd0) h_eff = (CW+1)'(1);
		else if (height_q > 6'(MAX_SIDE)) h_eff = (CW+1)'(MAX_SIDE);
		else h_eff = (CW+1)'(height_q);
	end

	// Neighbor offsets; relaxation and trace both use dx-major order.
	logic signed [1:0] ndx, ndy;
	always_comb begin
		unique case (nb_q[2:0])
			3'd0: begin ndx = -2'sd1; ndy = -2'sd1; end
			3'd1: begin ndx = -2'sd1; ndy = 2'sd0; end
			3'd2: begin ndx = -2'sd1; ndy = 2'sd1; end
			3'd3: begin ndx = 2'sd0; ndy = -2'sd1; end
			3'd4: begin ndx = 2'sd0; ndy = 2'sd1; end
			3'd5: begin ndx = 2'sd1; ndy = -2'sd1; end
			3'd6: begin ndx = 2'sd1; ndy = 2'sd0; end
			default: begin ndx = 2'sd1; ndy = 2'sd1; end
		endcase
	end

	logic [CW-1:0] cx_c, cy_c;
	assign cx_c = ctl.trace_step ? tx_q : bx_q;
	assign cy_c = ctl.trace_step ? ty_q : by_q;
	logic signed [CW+1:0] nx_s, ny_s;
	assign nx_s = $signed({2'b00, cx_c}) + (CW+2)'(ndx);
	assign ny_s = $signed({2'b00, cy_c}) + (CW+2)'(ndy);
	logic nb_in;
	assign nb_in = (nx_s >= 0) && (ny_s >= 0) && (nx_s < $signed({1'b0, w_eff}))
		&& (ny_s < $signed({1'b0, h_eff}));
	logic [CW-1:0] nx, ny;
	assign nx = nx_s[CW-1:0];
	assign ny = ny_s[CW-1:0];
	logic diag;
	assign diag = (ndx != 2'sd0) && (ndy != 2'sd0);

	// Scan visits cells x-major, matching the tie order.
	logic [CW-1:0] scx, scy;
	assign scx = cnt_q[AW-1:CW];
	assign scy = cnt_q[CW-1:0];
	logic sc_in;
	assign sc_in = ({1'b0, scx} < w_eff) && ({1'b0, scy} < h_eff);

	always_comb begin
		addr = {cmd_q.cell_y, cmd_q.cell_x};
		if (ctl.clear_step) addr = cnt_q[AW-1:0];
		else if (ctl.scan_step) addr = {scy, scx};
		else if (ctl.relax_step || ctl.trace_step) addr = {ny, nx};
		else if (ctl.seed) addr = {sy_q, sx_q};
		else if (ctl.settle) addr = {by_q, bx_q};
		else if (ctl.latch_cmd) addr = {cmd.cell_y, cmd.cell_x};
	end

	logic [13:0] nd;
	logic [14:0] nd_w;
	assign nd_w = {1'b0, bd_q} + (diag ? 15'd14 : 15'd10);
	assign nd = (nd_w > {1'b0, DIST_MAX}) ? DIST_MAX : nd_w[13:0];

	logic relax_wr, scan_act;
	assign relax_wr = ctl.relax_step && ph_q && nb_in
		&& kind_rd != KIND_OBSTACLE && vis_rd != VIS_DONE;
	assign scan_act = ctl.scan_step && ph_q && sc_in && vis_rd == VIS_WAIT
		&& (!any_q || dist_rd < bd_q);

	logic trace_better;
	assign trace_better = ctl.trace_step && ph_q && nb_in && (!any_q || dist_rd < bd_q);

	always_ff @(posedge clk) begin
		kind_rd <= kind_mem[addr];
		if (ctl.do_write) kind_mem[addr] <= cmd.cell_kind;
	end

	always_ff @(posedge clk) begin
		dist_rd <= dist_mem[addr];
		if (ctl.clear_step && !ph_q) dist_mem[addr] <= UNREACHED;
		else if (ctl.seed) dist_mem[addr] <= 14'd0;
		else if (relax_wr && nd < dist_rd) dist_mem[addr] <= nd;
	end

	always_ff @(posedge clk) begin
		vis_rd <= vis_mem[addr];
		if (ctl.clear_step && !ph_q) vis_mem[addr] <= VIS_NONE;
		else if (ctl.seed) vis_mem[addr] <= VIS_WAIT;
		else if (ctl.settle) vis_mem[addr] <= VIS_DONE;
		else if (relax_wr) vis_mem[addr] <= VIS_WAIT;
	end

	always_ff @(posedge clk) begin
		path_rd <= path_mem[addr];
		if (ctl.clear_step && !ph_q) path_mem[addr] <= 1'b0;
		else if (ctl.trace_start) path_mem[{by_q, bx_q}] <= 1'b1;
		else if (ctl.trace_step && ph_q && nb_q == 4'd8 && !tdone_q)
			path_mem[{by_q, bx_q}] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 6'd32;
			height_q <= 6'd32;
			sx_q <= '0;
			sy_q <= '0;
			flen_q <= '0;
			fdist_q <= UNREACHED;
			res_q <= '0;
			done_q <= 1'b0;
			cnt_q <= '0;
			ph_q <= 1'b0;
			any_q <= 1'b0;
			bd_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			nb_q <= '0;
			steps_q <= '0;
			tdone_q <= 1'b0;
		end else begin
			done_q <= ctl.finish_ok || ctl.finish_fail || ctl.finish_plain;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_START_X: sx_q <= cfg_data[4:0];
					REG_START_Y: sy_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (ctl.clear_start) begin
				cnt_q <= '0;
				ph_q <= 1'b0;
				flen_q <= '0;
				fdist_q <= UNREACHED;
			end
			if (ctl.clear_step) cnt_q <= cnt_q + 1'b1;
			if (ctl.seed || ctl.scan_start) begin
				cnt_q <= '0;
				any_q <= 1'b0;
			end
			if (ctl.seed) begin
				ph_q <= 1'b0;
				bx_q <= sx_q;
				by_q <= sy_q;
			end
			if (ctl.scan_step) begin
				ph_q <= ~ph_q;
				if (ph_q) cnt_q <= cnt_q + 1'b1;
				if (scan_act) begin
					any_q <= 1'b1;
					bd_q <= dist_rd;
					bx_q <= scx;
					by_q <= scy;
				end
			end
			if (ctl.relax_start) begin
				nb_q <= '0;
				ph_q <= 1'b0;
			end
			if (ctl.relax_step) begin
				ph_q <= ~ph_q;
				if (ph_q) nb_q <= nb_q + 1'b1;
			end
			if (ctl.trace_start) begin
				tx_q <= bx_q;
				ty_q <= by_q;
				fdist_q <= bd_q;
				steps_q <= '0;
				nb_q <= '0;
				ph_q <= 1'b0;
				any_q <= 1'b0;
				tdone_q <= (bx_q == sx_q) && (by_q == sy_q);
			end
			if (ctl.trace_step && !tdone_q) begin
				if (nb_q == 4'd8) begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						nb_q <= '0;
						any_q <= 1'b0;
						tx_q <= bx_q;
						ty_q <= by_q;
						if (steps_q != LEN_MAX) steps_q <= steps_q + 1'b1;
						tdone_q <= (bx_q == sx_q) && (by_q == sy_q);
					end
				end else begin
					ph_q <= ~ph_q;
					if (ph_q) nb_q <= nb_q + 1'b1;
					if (trace_better) begin
						any_q <= 1'b1;
						bd_q <= dist_rd;
						bx_q <= nx;
						by_q <= ny;
					end
				end
			end
			if (ctl.finish_ok) begin
				flen_q <= steps_q;
				res_q <= '{ST_FOUND, steps_q, fdist_q, 14'd0, 1'b0};
			end
			if (ctl.finish_fail) begin
				res_q <= '{ST_NOPATH, 11'd0, UNREACHED, 14'd0, 1'b0};
			end
			if (ctl.finish_plain) begin
				if (cmd_q.operation == OP_READ)
					res_q <= '{ST_DONE, flen_q, fdist_q, dist_rd, path_rd};
				else
					res_q <= '{ST_DONE, flen_q, fdist_q, 14'd0, 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_cmd) cmd_q <= cmd;
	end

	assign st.clear_last = ph_q == 1'b0 && cnt_q == (AW+1)'(CELLS - 1);
	assign st.scan_last = ph_q && cnt_q == (AW+1)'(CELLS - 1);
	assign st.start_ok = ({1'b0, sx_q} < w_eff) && ({1'b0, sy_q} < h_eff);
	assign st.any_found = any_q;
	assign st.is_finish = kind_rd == KIND_FINISH;
	assign st.relax_last = ph_q && nb_q == 4'd7;
	assign st.trace_end = tdone_q;
	assign done = done_q;
	assign res = res_q;
endmodule

// ----- sv/grid_shortest_path_finder.sv -----
// ---------------------------------------------------------------------------
// grid_shortest_path_finder
// Dijkstra search and trace back over an 8-connected grid of up to 32 by 32.
// ---------------------------------------------------------------------------
// busy is high until the result strobe. A run clears all 1024 cells and seeds the
// start, then repeatedly scans the store for the nearest waiting cell, settles it and
// relaxes its neighbors; the trace then walks back from the finish to the start. One
// item at a time; the result strobe cannot be stalled.
// After reset busy stays high while the distance, visit and path stores clear.
module grid_shortest_path_finder (
	input logic clk,
	input logic arst_n,
	input logic start,
	input gspf_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output gspf_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [5:0] cfg_data
);
	import gspf_pkg::*;

	ctrl_t ctl;
	stat_t st;

	assign cfg_ready = 1'b1;

	gspf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(cmd.operation),
		.st(st), .ctl(ctl), .busy(busy)
	);

	gspf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl),
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.st(st), .done(done), .res(result)
	);
endmodule

// ----- sv/gspf_checker.sv -----
// ---------------------------------------------------------------------------
// gspf_checker
// Port-level checks on the command and result handshake.
// ---------------------------------------------------------------------------
module gspf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input gspf_pkg::result_t result
);
	import gspf_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while still busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than a cycle");
	a_nopath: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_NOPATH |-> result.path_length == 11'd0)
		else $error("failed run reports a path length");
endmodule

bind grid_shortest_path_finder gspf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

// ----- tb/sv/grid_shortest_path_finder_tb.sv -----
// ---------------------------------------------------------------------------
// grid_shortest_path_finder_tb
// Self-checking bench for the grid shortest-path finder. After reset every cell
// that a directed run can look at is written free. A table of directed words
// then covers the grid size extremes, a start outside the grid, a start that is
// a finish, a walled-in start and several finishes. Random phases follow, each on
// a small grid with random cells, runs and reads. Each result is checked against
// a typed row's expected word or a search and trace back modeled inside the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_shortest_path_finder_tb;
	import gspf_pkg::*;

	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam logic [1:0] KIND_FREE = 2'd0;
	localparam logic [1:0] KIND_ODD = 2'd3;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int RANDOM_WORDS = 40;

	typedef struct {
		bit is_cfg;
		logic [1:0] idx;
		logic [5:0] val;
		cmd_t c;
		bit typed;
		result_t r;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	grid_shortest_path_finder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
		.result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [1:0] kind_mem [CELLS];
	logic [13:0] dist_mem [CELLS];
	logic [1:0] seen_mem [CELLS];
	logic on_path_mem [CELLS];
	logic [10:0] last_len;
	logic [13:0] last_dist;
	logic [5:0] grid_w, grid_h;
	logic [4:0] orig_x, orig_y;

	result_t pending_results [$];
	row_t rows [$];
	int errors;
	int cycles;
	int burst_left;
	int random_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("grid_shortest_path_finder test failed");
			$finish;
		end
	end

	function automatic int cell_at(int x, int y);
		return y * MAX_SIDE + x;
	endfunction

	function automatic int clamp_side(logic [5:0] v);
		if (v < 1) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	function automatic void search_and_trace();
		int w, h, bx, by, nx, ny, fx, fy, x, y, steps, nd;
		logic [23:0] best, key;
		bit any, found;
		w = clamp_side(grid_w);
		h = clamp_side(grid_h);
		for (int i = 0; i < CELLS; i++) begin
			dist_mem[i] = UNREACHED;
			seen_mem[i] = VIS_NONE;
			on_path_mem[i] = 1'b0;
		end
		last_len = '0;
		last_dist = UNREACHED;
		if (orig_x >= w || orig_y >= h) return;
		dist_mem[cell_at(orig_x, orig_y)] = '0;
		seen_mem[cell_at(orig_x, orig_y)] = VIS_WAIT;
		found = 0;
		forever begin
			any = 0;
			best = '0;
			for (int i = 0; i < w; i++)
				for (int j = 0; j < h; j++) begin
					key = {dist_mem[cell_at(i, j)], 5'(i), 5'(j)};
					if (seen_mem[cell_at(i, j)] == VIS_WAIT && (!any || key < best)) begin
						any = 1;
						best = key;
					end
				end
			if (!any) break;
			bx = best[9:5];
			by = best[4:0];
			seen_mem[cell_at(bx, by)] = VIS_DONE;
			if (kind_mem[cell_at(bx, by)] == KIND_FINISH) begin
				found = 1;
				fx = bx;
				fy = by;
				break;
			end
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++) begin
					nx = bx + dx;
					ny = by + dy;
					if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
					if (kind_mem[cell_at(nx, ny)] == KIND_OBSTACLE) continue;
					if (seen_mem[cell_at(nx, ny)] == VIS_DONE) continue;
					nd = best[23:10] + ((dx != 0 && dy != 0) ? 14 : 10);
					if (nd > DIST_MAX) nd = DIST_MAX;
					if (nd < dist_mem[cell_at(nx, ny)]) dist_mem[cell_at(nx, ny)] = 14'(nd);
					seen_mem[cell_at(nx, ny)] = VIS_WAIT;
				end
		end
		if (!found) return;
		last_dist = dist_mem[cell_at(fx, fy)];
		x = fx;
		y = fy;
		steps = 0;
		on_path_mem[cell_at(x, y)] = 1'b1;
		while ((x != orig_x || y != orig_y) && steps < CELLS) begin
			any = 0;
			best = '0;
			for (int dx = -1; dx <= 1; dx++)
				for (int dy = -1; dy <= 1; dy++) begin
					nx = x + dx;
					ny = y + dy;
					if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
					key = {dist_mem[cell_at(nx, ny)], 5'(nx), 5'(ny)};
					if (!any || key < best) begin
						any = 1;
						best = key;
					end
				end
			if (!any) break;
			x = best[9:5];
			y = best[4:0];
			on_path_mem[cell_at(x, y)] = 1'b1;
			steps++;
		end
		last_len = 11'((steps > LEN_MAX) ? LEN_MAX : steps);
	endfunction

	function automatic result_t predict_result(cmd_t c);
		result_t r;
		r = '0;
		case (c.operation)
			OP_WRITE: kind_mem[cell_at(c.cell_x, c.cell_y)] = c.cell_kind;
			OP_RUN: begin
				search_and_trace();
				r.status = (last_dist == UNREACHED) ? ST_NOPATH : ST_FOUND;
			end
			OP_READ: begin
				r.cell_distance = dist_mem[cell_at(c.cell_x, c.cell_y)];
				r.cell_on_path = on_path_mem[cell_at(c.cell_x, c.cell_y)];
			end
			default: ;
		endcase
		r.path_length = last_len;
		r.finish_distance = last_dist;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (result.path_length !== want.path_length) begin
					$error("path_length: expected %0d, got %0d", want.path_length,
						result.path_length);
					errors++;
				end
				if (result.finish_distance !== want.finish_distance) begin
					$error("finish_distance: expected %0d, got %0d", want.finish_distance,
						result.finish_distance);
					errors++;
				end
				if (result.cell_distance !== want.cell_distance) begin
					$error("cell_distance: expected %0d, got %0d", want.cell_distance,
						result.cell_distance);
					errors++;
				end
				if (result.cell_on_path !== want.cell_on_path) begin
					$error("cell_on_path: expected %0d, got %0d", want.cell_on_path,
						result.cell_on_path);
					errors++;
				end
			end
		end
	end

	task automatic send(cmd_t c, bit typed, result_t r);
		result_t model_r;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start = 1'b1;
		cmd = c;
		do @(posedge clk); while (busy);
		model_r = predict_result(c);
		pending_results.push_back(typed ? r : model_r);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		wait (pending_results.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH: grid_w = val;
			REG_HEIGHT: grid_h = val;
			REG_START_X: orig_x = val[4:0];
			default: orig_y = val[4:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [5:0] val);
		row_t w;
		w = '{default: '0};
		w.is_cfg = 1;
		w.idx = idx;
		w.val = val;
		rows.push_back(w);
	endtask

	task automatic add_cmd(logic [1:0] op, int x, int y, logic [1:0] k);
		row_t w;
		w = '{default: '0};
		w.c = '{op, 5'(x), 5'(y), k};
		rows.push_back(w);
	endtask

	task automatic add_exp(logic [1:0] op, int x, int y, logic [1:0] k, logic [1:0] st,
		int len, int fd, int cd, bit on);
		row_t w;
		w = '{default: '0};
		w.c = '{op, 5'(x), 5'(y), k};
		w.typed = 1;
		w.r = '{st, 11'(len), 14'(fd), 14'(cd), on};
		rows.push_back(w);
	endtask

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return KIND_FREE;
		if (r < 17) return KIND_OBSTACLE;
		if (r < 19) return KIND_FINISH;
		return KIND_ODD;
	endfunction

	initial begin
		int w, h;
		cmd_t c;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		random_sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		grid_w = 6'd32;
		grid_h = 6'd32;
		orig_x = '0;
		orig_y = '0;
		last_len = '0;
		last_dist = UNREACHED;
		for (int i = 0; i < CELLS; i++) begin
			kind_mem[i] = KIND_FREE;
			dist_mem[i] = UNREACHED;
			seen_mem[i] = VIS_NONE;
			on_path_mem[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_exp(OP_READ, 0, 0, KIND_FREE, ST_DONE, 0, 16383, 16383, 0);
		add_exp(OP_READ, 31, 31, KIND_FREE, ST_DONE, 0, 16383, 16383, 0);
		add_cfg(REG_WIDTH, 6'd0);
		add_cfg(REG_HEIGHT, 6'd63);
		add_cfg(REG_START_Y, 6'd31);
		add_cmd(OP_WRITE, 0, 0, KIND_FINISH);
		add_exp(OP_RUN, 0, 0, KIND_FREE, ST_FOUND, 31, 310, 0, 0);
		add_cmd(OP_READ, 0, 15, KIND_FREE);
		add_cmd(OP_READ, 31, 31, KIND_FREE);
		add_cmd(OP_IDLE, 31, 31, KIND_FINISH);
		add_cfg(REG_WIDTH, 6'd63);
		add_cfg(REG_START_X, 6'd31);
		add_cmd(OP_WRITE, 31, 31, KIND_FINISH);
		add_exp(OP_RUN, 0, 0, KIND_FREE, ST_FOUND, 0, 0, 0, 0);
		add_exp(OP_READ, 31, 31, KIND_FREE, ST_DONE, 0, 0, 0, 1);
		add_cfg(REG_WIDTH, 6'd3);
		add_cfg(REG_HEIGHT, 6'd3);
		add_exp(OP_RUN, 0, 0, KIND_FREE, ST_NOPATH, 0, 16383, 0, 0);
		add_cfg(REG_START_X, 6'd0);
		add_cfg(REG_START_Y, 6'd0);
		add_cmd(OP_WRITE, 0, 0, KIND_ODD);
		add_cmd(OP_WRITE, 1, 0, KIND_OBSTACLE);
		add_cmd(OP_WRITE, 0, 1, KIND_OBSTACLE);
		add_cmd(OP_WRITE, 1, 1, KIND_OBSTACLE);
		add_cmd(OP_WRITE, 2, 2, KIND_FINISH);
		add_exp(OP_RUN, 0, 0, KIND_FREE, ST_NOPATH, 0, 16383, 0, 0);
		add_cmd(OP_WRITE, 1, 1, KIND_FREE);
		add_exp(OP_RUN, 0, 0, KIND_FREE, ST_FOUND, 2, 28, 0, 0);
		add_cmd(OP_READ, 1, 1, KIND_FREE);
		add_cmd(OP_WRITE, 1, 0, KIND_FINISH);
		add_cmd(OP_RUN, 0, 0, KIND_FREE);

		// Give a kind to every cell that a directed run can look at.
		for (int y = 0; y < MAX_SIDE; y++) begin
			c = '{OP_WRITE, 5'(0), 5'(y), KIND_FREE};
			send(c, 0, '0);
		end
		for (int x = 1; x < 3; x++)
			for (int y = 0; y < 3; y++) begin
				c = '{OP_WRITE, 5'(x), 5'(y), KIND_FREE};
				send(c, 0, '0);
			end
		drain();

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
			else send(rows[i].c, rows[i].typed, rows[i].r);
		end

		while (random_sent < RANDOM_WORDS) begin
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
			h = $urandom_range(1, 5);
			write_reg(REG_WIDTH, 6'(w));
			write_reg(REG_HEIGHT, 6'(h));
			write_reg(REG_START_X, ($urandom_range(0, 7) == 0) ? 6'(31) :
				6'($urandom_range(0, clamp_side(6'(w)) - 1)));
			write_reg(REG_START_Y, 6'($urandom_range(0, h - 1)));
			for (int x = 0; x < clamp_side(6'(w)); x++)
				for (int y = 0; y < h; y++) begin
					c = '{OP_WRITE, 5'(x), 5'(y), pick_kind()};
					send(c, 0, '0);
					random_sent++;
				end
			for (int k = 0; k < 2; k++) begin
				c = '{OP_WRITE, 5'($urandom), 5'($urandom), 2'($urandom)};
				send(c, 0, '0);
				c = '{OP_RUN, 5'($urandom), 5'($urandom), 2'($urandom)};
				send(c, 0, '0);
				if ($urandom_range(0, 1)) drain();
				for (int j = 0; j < 6; j++) begin
					if (j == 5)
						c = '{OP_IDLE, 5'($urandom), 5'($urandom), 2'($urandom)};
					else if (j == 4)
						c = '{OP_READ, 5'($urandom), 5'($urandom), 2'($urandom)};
					else
						c = '{OP_READ, 5'($urandom_range(0, clamp_side(6'(w)) - 1)),
							5'($urandom_range(0, h - 1)), 2'($urandom)};
					send(c, 0, '0);
				end
				random_sent += 8;
			end
		end

		wait (pending_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("grid_shortest_path_finder test passed");
		end else begin
			$display("grid_shortest_path_finder test failed");
		end
		$finish;
	end

endmodule
